// File: sv/sliding_window_traffic_monitor_unit_assert.svh
// Assertion macros shared by the checker of the traffic monitor.
`ifndef SLIDING_WINDOW_TRAFFIC_MONITOR_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_TRAFFIC_MONITOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWTM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWTM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/swtm_pkg.sv
`timescale 1ns / 1ps
package swtm_pkg;

   localparam int ROUTERS_DEF    = 8;
   localparam int MAX_OPEN_DEF   = 4;
   localparam int COUNT_BITS_DEF = 24;

   localparam logic [1:0] CMD_SWITCH = 2'd0;
   localparam logic [1:0] CMD_INJECT = 2'd1;
   localparam logic [1:0] CMD_ACCEPT = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   localparam logic [1:0] CSR_WIDTH = 2'd0;
   localparam logic [1:0] CSR_STEP  = 2'd1;

   localparam logic [15:0] WIDTH_RESET = 16'd1000;
   localparam logic [15:0] STEP_RESET  = 16'd1000;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] event_time;
      logic [2:0]  src_router;
      logic [2:0]  dst_router;
      logic [7:0]  flit_count;
   } req_type;

   typedef struct packed {
      logic [31:0] window_start;
      logic [2:0]  router_id;
      logic [23:0] through_flits;
      logic [23:0] inject_flits;
      logic [23:0] accept_flits;
      logic [31:0] empty_windows;
      logic        last;
   } rsp_type;

endpackage

// File: sv/swtm_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle.
module swtm_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        busy,
   output logic [31:0] quotient
);

   logic        busy_ff;
   logic [4:0]  cnt_ff;
   logic [15:0] rem_ff;
   logic [31:0] quo_ff;
   logic [16:0] rem_sh;
   logic [16:0] diff;
   logic        fits;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[31]};
      diff   = rem_sh - {1'b0, divisor};
      fits   = rem_sh >= {1'b0, divisor};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         quo_ff  <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[15:0] : rem_sh[15:0];
         quo_ff <= {quo_ff[30:0], fits};
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// File: sv/swtm_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with a registered read.
module swtm_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 72,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sliding_window_traffic_monitor_unit.sv
`timescale 1ns / 1ps
// Sliding-window traffic monitor. Trace events (flit switch, packet inject, packet accept)
// arrive in nondecreasing time order and are counted into overlapping windows. Each window
// is as long as the width register says, a new one opens every step register units, and the
// first starts at time 0. Each window keeps saturating per-router counters in one counter
// RAM, addressed by window slot and router. When an event reaches the end of the oldest
// windows, those windows close and are sent out oldest first, one transaction per router;
// windows that a time jump skips entirely are reported in a single summary transaction. The
// last transaction caused by an event carries last = 1. The block works on one event at a
// time. An event with the unused command code is taken and changes nothing. Any other
// event holds req_stall high while the block closes the windows it reaches, opens new
// ones, checks each open window and, for each window that holds it, reads its counter from
// the RAM and writes it back, and while it sends the router and summary transactions,
// which the receiver can stall. An event that reaches a later window start also waits for
// the shared serial divider to find the number of new starts, and then the number of
// skipped windows when it lies at least one width past the newest start. After reset and
// after every register write the counter RAM is swept to zero, one entry a cycle, over all
// MAX_OPEN * 2**ceil(log2(ROUTERS)) entries (32 with the defaults); events are held off
// during the sweep, register writes are always taken. Registers should be written only
// while the block is idle; a write to either register also restarts the windows as after
// reset.
module sliding_window_traffic_monitor_unit #(
   parameter int ROUTERS    = swtm_pkg::ROUTERS_DEF,
   parameter int MAX_OPEN   = swtm_pkg::MAX_OPEN_DEF,
   parameter int COUNT_BITS = swtm_pkg::COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  swtm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output swtm_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);

   // Widths derived from the configuration.
   localparam int RB    = (ROUTERS > 1) ? $clog2(ROUTERS) : 1;
   localparam int SW    = (MAX_OPEN > 1) ? $clog2(MAX_OPEN) : 1;
   localparam int CW    = $clog2(MAX_OPEN + 1);
   localparam int AW    = SW + RB;
   localparam int DEPTH = MAX_OPEN * (2 ** RB);
   localparam int MW    = 3 * COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [4:0] {
      S_CLR,
      S_IDLE,
      S_SCAN,
      S_DIVN_GO,
      S_DIVN,
      S_DIVS_GO,
      S_DIVS,
      S_EM_GO,
      S_EM_RD,
      S_EM_LD,
      S_EM_TX,
      S_MUL1,
      S_MUL2,
      S_OPEN,
      S_SUM,
      S_CNT_CHK,
      S_CNT_WR
   } state_type;

   // Ring position of the window that lies off entries after the base slot.
   function automatic logic [SW-1:0] ring(input logic [SW-1:0] base,
                                          input logic [CW-1:0] off);
      logic [SW+1:0] s;
      s = (SW+2)'(base) + (SW+2)'(off);
      if (s >= (SW+2)'(MAX_OPEN)) begin
         s = s - (SW+2)'(MAX_OPEN);
      end
      return s[SW-1:0];
   endfunction

   // Saturating add of an event amount to one counter.
   function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] c,
                                                     input logic [7:0] a);
      logic [COUNT_BITS:0] s;
      s = (COUNT_BITS+1)'(c) + (COUNT_BITS+1)'(a);
      if (s >= (COUNT_BITS+1)'(COUNT_MAX)) begin
         return COUNT_MAX;
      end
      return s[COUNT_BITS-1:0];
   endfunction

   state_type          state_ff;
   logic [15:0]        width_ff;
   logic [15:0]        step_ff;
   logic [31:0]        start_ff [MAX_OPEN];
   logic [CW-1:0]      count_ff;
   logic [SW-1:0]      oldest_ff;
   logic [31:0]        newest_ff;
   swtm_pkg::req_type  ev_ff;
   logic [15:0]        w_ff;
   logic [15:0]        stepe_ff;
   logic [CW-1:0]      idx_ff;
   logic [CW-1:0]      nclose_ff;
   logic [RB-1:0]      rt_ff;
   logic [31:0]        d_ff;
   logic [31:0]        n_ff;
   logic [31:0]        skip_ff;
   logic [31:0]        prod_ff;
   logic [31:0]        nxt_ff;
   logic [31:0]        open_left_ff;
   logic [AW-1:0]      clr_ff;
   logic [AW-1:0]      addr_ff;
   swtm_pkg::rsp_type  rsp_ff;
   logic               rsp_valid_ff;

   logic [15:0]        width_e;
   logic [15:0]        step_e;
   logic [31:0]        cap;
   logic [15:0]        w_eff;
   logic [SW-1:0]      cur_slot;
   logic [31:0]        cur_start;
   logic               in_close;
   logic [2:0]         ev_router;
   logic               router_ok;
   logic               div_start;
   logic [31:0]        div_dividend;
   logic               div_busy;
   logic [31:0]        div_quotient;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [MW-1:0]      mem_wdata;
   logic [AW-1:0]      mem_raddr;
   logic [MW-1:0]      mem_rdata;
   logic               cond_n;
   logic               cond_s;
   logic               restart;

   // Effective window length: zero registers count as one, and the width is clamped so
   // that no more than MAX_OPEN windows overlap.
   always_comb begin
      width_e = (width_ff == 16'd0) ? 16'd1 : width_ff;
      step_e  = (step_ff == 16'd0) ? 16'd1 : step_ff;
      cap     = 32'(MAX_OPEN) * 32'(step_e);
      w_eff   = (32'(width_e) > cap) ? cap[15:0] : width_e;
   end

   // One read of the start-time ring per cycle, at the window idx_ff entries past the oldest.
   always_comb begin
      cur_slot  = ring(oldest_ff, idx_ff);
      cur_start = start_ff[cur_slot];
      in_close  = (33'(cur_start) + 33'(w_ff)) <= 33'(ev_ff.event_time);
      ev_router = (ev_ff.cmd == swtm_pkg::CMD_ACCEPT) ? ev_ff.dst_router : ev_ff.src_router;
      router_ok = 7'(ev_router) < 7'(ROUTERS);
      cond_n    = (ev_ff.event_time >= newest_ff) && (d_ff >= 32'(stepe_ff));
      cond_s    = d_ff >= 32'(w_ff);
      restart   = csr_valid && csr_ready &&
                  ((csr_index == swtm_pkg::CSR_WIDTH) || (csr_index == swtm_pkg::CSR_STEP));
   end

   // Shared divider: first the number of new window starts, then the number skipped.
   always_comb begin
      div_start    = ((state_ff == S_DIVN_GO) && cond_n) ||
                     ((state_ff == S_DIVS_GO) && cond_s);
      div_dividend = (state_ff == S_DIVS_GO) ? (d_ff - 32'(w_ff)) : d_ff;
   end

   swtm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (stepe_ff),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   // Counter RAM port control. A read is always issued; the write port serves the clear
   // sweep, the zeroing of a window as it is sent out, and the counter update.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = mem_rdata;
      mem_raddr = {oldest_ff, rt_ff};
      unique case (state_ff)
         S_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         S_EM_LD: begin
            mem_we    = 1'b1;
            mem_waddr = {oldest_ff, rt_ff};
            mem_wdata = '0;
         end
         S_CNT_CHK: begin
            mem_raddr = {cur_slot, RB'(ev_router)};
         end
         S_CNT_WR: begin
            mem_we = 1'b1;
            unique case (ev_ff.cmd)
               swtm_pkg::CMD_SWITCH: begin
                  mem_wdata[2*COUNT_BITS +: COUNT_BITS] =
                     sat_add(mem_rdata[2*COUNT_BITS +: COUNT_BITS], 8'd1);
               end
               swtm_pkg::CMD_INJECT: begin
                  mem_wdata[COUNT_BITS +: COUNT_BITS] =
                     sat_add(mem_rdata[COUNT_BITS +: COUNT_BITS], ev_ff.flit_count);
               end
               swtm_pkg::CMD_ACCEPT: begin
                  mem_wdata[0 +: COUNT_BITS] =
                     sat_add(mem_rdata[0 +: COUNT_BITS], ev_ff.flit_count);
               end
               default: begin
                  mem_we = 1'b0;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   swtm_ram #(
      .DEPTH (DEPTH),
      .WIDTH (MW),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Main sequencer: holds the window ring, the event being worked on and the output
   // register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         width_ff     <= swtm_pkg::WIDTH_RESET;
         step_ff      <= swtm_pkg::STEP_RESET;
         count_ff     <= CW'(1);
         oldest_ff    <= '0;
         newest_ff    <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_OPEN; i++) begin
            start_ff[i] <= '0;
         end
      end else if (restart) begin
         // A register write restarts the windows and sweeps the counters again.
         if (csr_index == swtm_pkg::CSR_WIDTH) begin
            width_ff <= csr_data;
         end
         if (csr_index == swtm_pkg::CSR_STEP) begin
            step_ff <= csr_data;
         end
         state_ff     <= S_CLR;
         count_ff     <= CW'(1);
         oldest_ff    <= '0;
         newest_ff    <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_OPEN; i++) begin
            start_ff[i] <= '0;
         end
      end else begin
         unique case (state_ff)
            S_CLR: begin
               if (clr_ff == AW'(DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end else begin
                  clr_ff <= clr_ff + AW'(1);
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  ev_ff    <= req_data;
                  w_ff     <= w_eff;
                  stepe_ff <= step_e;
                  idx_ff   <= '0;
                  if (req_data.cmd != swtm_pkg::CMD_NONE) begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               // Count how many of the oldest windows this event closes.
               if ((idx_ff < count_ff) && in_close) begin
                  idx_ff <= idx_ff + CW'(1);
               end else begin
                  nclose_ff <= idx_ff;
                  d_ff      <= ev_ff.event_time - newest_ff;
                  n_ff      <= '0;
                  skip_ff   <= '0;
                  state_ff  <= S_DIVN_GO;
               end
            end
            S_DIVN_GO: begin
               state_ff <= cond_n ? S_DIVN : S_EM_GO;
            end
            S_DIVN: begin
               if (!div_busy) begin
                  n_ff     <= div_quotient;
                  state_ff <= S_DIVS_GO;
               end
            end
            S_DIVS_GO: begin
               state_ff <= cond_s ? S_DIVS : S_EM_GO;
            end
            S_DIVS: begin
               if (!div_busy) begin
                  skip_ff  <= div_quotient;
                  state_ff <= S_EM_GO;
               end
            end
            S_EM_GO: begin
               idx_ff   <= '0;
               rt_ff    <= '0;
               state_ff <= (nclose_ff != '0) ? S_EM_RD : S_MUL1;
            end
            S_EM_RD: begin
               state_ff <= S_EM_LD;
            end
            S_EM_LD: begin
               rsp_ff.window_start  <= cur_start;
               rsp_ff.router_id     <= 3'(rt_ff);
               rsp_ff.through_flits <= 24'(mem_rdata[2*COUNT_BITS +: COUNT_BITS]);
               rsp_ff.inject_flits  <= 24'(mem_rdata[COUNT_BITS +: COUNT_BITS]);
               rsp_ff.accept_flits  <= 24'(mem_rdata[0 +: COUNT_BITS]);
               rsp_ff.empty_windows <= '0;
               rsp_ff.last          <= (rt_ff == RB'(ROUTERS - 1)) &&
                                       (nclose_ff == CW'(1)) && (skip_ff == '0);
               rsp_valid_ff         <= 1'b1;
               state_ff             <= S_EM_TX;
            end
            S_EM_TX: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (rt_ff == RB'(ROUTERS - 1)) begin
                     oldest_ff <= ring(oldest_ff, CW'(1));
                     count_ff  <= count_ff - CW'(1);
                     nclose_ff <= nclose_ff - CW'(1);
                     rt_ff     <= '0;
                     state_ff  <= (nclose_ff == CW'(1)) ? S_MUL1 : S_EM_RD;
                  end else begin
                     rt_ff    <= rt_ff + RB'(1);
                     state_ff <= S_EM_RD;
                  end
               end
            end
            S_MUL1: begin
               prod_ff  <= 32'(skip_ff * 32'(stepe_ff));
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               nxt_ff       <= newest_ff + prod_ff + 32'(stepe_ff);
               open_left_ff <= n_ff - skip_ff;
               prod_ff      <= 32'(n_ff * 32'(stepe_ff));
               // The summary transaction is prepared here and sent only if windows
               // were skipped.
               rsp_ff.window_start  <= newest_ff + 32'(stepe_ff);
               rsp_ff.router_id     <= '0;
               rsp_ff.through_flits <= '0;
               rsp_ff.inject_flits  <= '0;
               rsp_ff.accept_flits  <= '0;
               rsp_ff.empty_windows <= skip_ff;
               rsp_ff.last          <= 1'b1;
               state_ff             <= S_OPEN;
            end
            S_OPEN: begin
               if ((open_left_ff != '0) && (count_ff < CW'(MAX_OPEN))) begin
                  start_ff[ring(oldest_ff, count_ff)] <= nxt_ff;
                  count_ff     <= count_ff + CW'(1);
                  nxt_ff       <= nxt_ff + 32'(stepe_ff);
                  open_left_ff <= open_left_ff - 32'd1;
               end else begin
                  newest_ff <= newest_ff + prod_ff;
                  idx_ff    <= '0;
                  if (skip_ff != '0) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_SUM;
                  end else begin
                     state_ff <= S_CNT_CHK;
                  end
               end
            end
            S_SUM: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_CNT_CHK;
               end
            end
            S_CNT_CHK: begin
               // Read-modify-write of one counter per open window that holds the event.
               if (idx_ff == count_ff) begin
                  state_ff <= S_IDLE;
               end else if ((cur_start <= ev_ff.event_time) && router_ok) begin
                  addr_ff  <= {cur_slot, RB'(ev_router)};
                  state_ff <= S_CNT_WR;
               end else begin
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            S_CNT_WR: begin
               idx_ff   <= idx_ff + CW'(1);
               state_ff <= S_CNT_CHK;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

// File: sv/swtm_checker.sv
`timescale 1ns / 1ps
`include "sliding_window_traffic_monitor_unit_assert.svh"
// Port-level checks of the traffic monitor.
module swtm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input swtm_pkg::rsp_type rsp_data
);

   `SWTM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result transaction changed")
   `SWTM_ASSERT_NOW(a_busy_while_rsp, clock, reset, rsp_valid, req_stall && !(req_valid && !req_stall), "event taken while a result is pending")
   `SWTM_ASSERT_NOW(a_summary_shape, clock, reset, rsp_valid && (rsp_data.empty_windows != 32'd0), rsp_data.last && (rsp_data.router_id == 3'd0) && (rsp_data.through_flits == 24'd0) && (rsp_data.inject_flits == 24'd0) && (rsp_data.accept_flits == 24'd0), "malformed summary transaction")
   `SWTM_ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && !rsp_stall && rsp_data.last, !rsp_valid, "result transaction after the last one of an event")

endmodule

bind sliding_window_traffic_monitor_unit swtm_checker u_swtm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
